[rtl/cpe_pkg.sv]
package cpe_pkg;

  localparam int MaxTerms = 8;
  localparam int DataW    = 16;
  localparam int SlotW    = 3;
  localparam int TermCntW = 4;
  localparam int FracW    = 12;
  localparam int ProdW    = 2 * DataW;
  localparam int SumW     = ProdW + 1;
  localparam int AccW     = SumW + $clog2(MaxTerms);

  localparam logic signed [DataW-1:0] OneQ12 = DataW'(1 << FracW);
  localparam logic [TermCntW-1:0] TermCntRst = TermCntW'(2);

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_EVAL = 1'b1
  } cmd_e;

  typedef struct packed {
    logic                    valid;
    cmd_e                    cmd;
    logic [SlotW-1:0]        slot;
    logic signed [DataW-1:0] x_re;
    logic signed [DataW-1:0] x_im;
    logic signed [DataW-1:0] t_re;
    logic signed [DataW-1:0] t_im;
    logic signed [AccW-1:0]  acc_re;
    logic signed [AccW-1:0]  acc_im;
  } stage_t;

  typedef struct packed {
    logic signed [DataW-1:0] val;
    logic                    sat;
  } rnd_sat_t;

  // Round half up from Q12.24 to Q4.12, then clamp to the 16-bit range.
  function automatic rnd_sat_t rnd_sat(input logic signed [AccW-1:0] v);
    localparam logic signed [AccW:0] Half   = (AccW + 1)'(1 << (FracW - 1));
    localparam logic signed [AccW:0] SatMax = (AccW + 1)'(32767);
    localparam logic signed [AccW:0] SatMin = -(AccW + 1)'(32768);
    logic signed [AccW:0] t;
    rnd_sat_t r;
    t = $signed({v[AccW-1], v}) + Half;
    t = t >>> FracW;
    if (t > SatMax) begin
      r.val = 16'sh7fff;
      r.sat = 1'b1;
    end else if (t < SatMin) begin
      r.val = 16'sh8000;
      r.sat = 1'b1;
    end else begin
      r.val = t[DataW-1:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

  function automatic logic signed [AccW-1:0] ext_sum(input logic signed [SumW-1:0] v);
    return {{(AccW - SumW){v[SumW-1]}}, v};
  endfunction

endpackage

[rtl/cpe_if.sv]
interface cpe_in_if import cpe_pkg::*; ();
  logic                    valid;
  logic                    ready;
  cmd_e                    cmd;
  logic [SlotW-1:0]        coef_index;
  logic signed [DataW-1:0] data_re;
  logic signed [DataW-1:0] data_im;

  modport source (output valid, cmd, coef_index, data_re, data_im, input ready);
  modport sink (input valid, cmd, coef_index, data_re, data_im, output ready);
endinterface

interface cpe_out_if import cpe_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] result_re;
  logic signed [DataW-1:0] result_im;
  logic                    overflow;

  modport source (output valid, result_re, result_im, overflow, input ready);
  modport sink (input valid, result_re, result_im, overflow, output ready);
endinterface

[rtl/complex_polynomial_evaluator_core.sv]
// An accepted evaluate beat passes the input register, every term stage and the output register to its result beat.
// Throughput: one beat per cycle; the whole pipeline stalls only when the result is not taken.
// Each term stage owns its coefficient, so a load updates it as the load passes that stage.
// Load beats travel the pipeline and produce no result beat.
// Reset empties the pipeline, sets term_count to 2, the coefficient in slot one to 1.0 and all others to zero.
module complex_polynomial_evaluator_core import cpe_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [TermCntW-1:0] cfg_wdata_i,
  cpe_in_if.sink              src_i,
  cpe_out_if.source           res_o
);

  logic                    adv;
  logic [TermCntW-1:0]     term_count_q;
  stage_t                  in_q;
  stage_t                  st [MaxTerms+1];
  logic signed [DataW-1:0] coef_re_q [MaxTerms];
  logic signed [DataW-1:0] coef_im_q [MaxTerms];
  rnd_sat_t                out_re, out_im;
  logic                    out_valid_q;
  logic signed [DataW-1:0] out_re_q, out_im_q;
  logic                    out_ovf_q;

  // The pipeline moves whenever the output register is free or being emptied.
  assign adv         = !out_valid_q || res_o.ready;
  assign src_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_count_q <= TermCntRst;
    end else if (cfg_we_i) begin
      term_count_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_q <= '0;
    end else if (adv) begin
      in_q.valid  <= src_i.valid;
      in_q.cmd    <= src_i.cmd;
      in_q.slot   <= src_i.coef_index;
      in_q.x_re   <= src_i.data_re;
      in_q.x_im   <= src_i.data_im;
      in_q.t_re   <= OneQ12;
      in_q.t_im   <= '0;
      in_q.acc_re <= '0;
      in_q.acc_im <= '0;
    end
  end

  assign st[0] = in_q;

  for (genvar k = 0; k < MaxTerms; k++) begin : g_term
    logic hit;
    logic active;

    assign hit    = st[k].valid && (st[k].cmd == CMD_LOAD) && (32'(st[k].slot) == k);
    assign active = (st[k].cmd == CMD_EVAL) && (32'(term_count_q) > k);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        coef_re_q[k] <= (k == 1) ? OneQ12 : '0;
        coef_im_q[k] <= '0;
      end else if (adv && hit) begin
        coef_re_q[k] <= st[k].x_re;
        coef_im_q[k] <= st[k].x_im;
      end
    end

    cpe_term u_term (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .adv_i     (adv),
      .st_i      (st[k]),
      .coef_re_i (coef_re_q[k]),
      .coef_im_i (coef_im_q[k]),
      .active_i  (active),
      .st_o      (st[k+1])
    );
  end

  assign out_re = rnd_sat(st[MaxTerms].acc_re);
  assign out_im = rnd_sat(st[MaxTerms].acc_im);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_re_q    <= '0;
      out_im_q    <= '0;
      out_ovf_q   <= 1'b0;
    end else if (adv) begin
      out_valid_q <= st[MaxTerms].valid && (st[MaxTerms].cmd == CMD_EVAL);
      out_re_q    <= out_re.val;
      out_im_q    <= out_im.val;
      out_ovf_q   <= out_re.sat || out_im.sat;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.result_re = out_re_q;
  assign res_o.result_im = out_im_q;
  assign res_o.overflow  = out_ovf_q;

`ifndef NO_ASSERTIONS
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !src_i.ready |-> res_o.valid)
    else $error("input stalled without a pending result");

  a_zero_terms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (term_count_q == '0) |->
      (res_o.result_re == '0) && (res_o.result_im == '0) && !res_o.overflow)
    else $error("empty polynomial gave a nonzero result");

  a_ovf_on_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.overflow |->
      (res_o.result_re == 16'sh7fff) || (res_o.result_re == 16'sh8000) ||
      (res_o.result_im == 16'sh7fff) || (res_o.result_im == 16'sh8000))
    else $error("overflow flagged on an unsaturated result");
`endif

endmodule

[rtl/cpe_term.sv]
module cpe_term import cpe_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    adv_i,
  input  stage_t                  st_i,
  input  logic signed [DataW-1:0] coef_re_i,
  input  logic signed [DataW-1:0] coef_im_i,
  input  logic                    active_i,
  output stage_t                  st_o
);

  logic signed [ProdW-1:0] c_rr, c_ii, c_ri, c_ir;
  logic signed [ProdW-1:0] p_rr, p_ii, p_ri, p_ir;
  logic signed [SumW-1:0]  term_re, term_im, pow_re, pow_im;
  rnd_sat_t                pr_re, pr_im;
  stage_t                  st_d, st_q;

  assign c_rr = coef_re_i * st_i.t_re;
  assign c_ii = coef_im_i * st_i.t_im;
  assign c_ri = coef_re_i * st_i.t_im;
  assign c_ir = coef_im_i * st_i.t_re;

  assign p_rr = st_i.t_re * st_i.x_re;
  assign p_ii = st_i.t_im * st_i.x_im;
  assign p_ri = st_i.t_re * st_i.x_im;
  assign p_ir = st_i.t_im * st_i.x_re;

  assign term_re = $signed({c_rr[ProdW-1], c_rr}) - $signed({c_ii[ProdW-1], c_ii});
  assign term_im = $signed({c_ri[ProdW-1], c_ri}) + $signed({c_ir[ProdW-1], c_ir});
  assign pow_re  = $signed({p_rr[ProdW-1], p_rr}) - $signed({p_ii[ProdW-1], p_ii});
  assign pow_im  = $signed({p_ri[ProdW-1], p_ri}) + $signed({p_ir[ProdW-1], p_ir});

  assign pr_re = rnd_sat(ext_sum(pow_re));
  assign pr_im = rnd_sat(ext_sum(pow_im));

  always_comb begin
    st_d      = st_i;
    st_d.t_re = pr_re.val;
    st_d.t_im = pr_im.val;
    if (active_i) begin
      st_d.acc_re = st_i.acc_re + ext_sum(term_re);
      st_d.acc_im = st_i.acc_im + ext_sum(term_im);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (adv_i) begin
      st_q <= st_d;
    end
  end

  assign st_o = st_q;

endmodule
